@@ hw/rtl/lthp_pkg.sv @@
package lthp_pkg;

  localparam int unsigned POS_W        = 8;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned LEN_W        = 33;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned OUT_TUSER_W  = 3;
  localparam int unsigned WINDOW_BYTES_DEF = 128;

  // Header layout positions
  localparam logic [POS_W-1:0] ID3_IDENT_END  = 8'd3;
  localparam logic [POS_W-1:0] ID3_VER_HI     = 8'd3;
  localparam logic [POS_W-1:0] ID3_VER_LO     = 8'd4;
  localparam logic [POS_W-1:0] ID3_FLAGS_POS  = 8'd5;
  localparam logic [POS_W-1:0] ID3_SIZE_LAST  = 8'd9;
  localparam logic [POS_W-1:0] APE_IDENT_END  = 8'd8;
  localparam logic [POS_W-1:0] APE_VER_END    = 8'd12;
  localparam logic [POS_W-1:0] APE_VER_LAST   = 8'd11;
  localparam logic [POS_W-1:0] APE_SIZE_END   = 8'd16;
  localparam logic [POS_W-1:0] APE_FLAGS_TOP  = 8'd23;
  localparam logic [POS_W-1:0] APE_RSVD_START = 8'd24;
  localparam logic [POS_W-1:0] APE_RSVD_END   = 8'd32;
  localparam logic [POS_W-1:0] APE_HDR_LAST   = 8'd31;

  localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hff;
  localparam logic [WORD_W-1:0] APE_VER_1000  = 32'd1000;
  localparam logic [WORD_W-1:0] APE_VER_2000  = 32'd2000;
  localparam logic [LEN_W-1:0]  ID3_HDR_LEN   = 33'd10;
  localparam logic [LEN_W-1:0]  ID3_HDR_FOOT_LEN = 33'd20;
  localparam logic [LEN_W-1:0]  APE_HDR_LEN   = 33'd32;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_ID3  = 2'd1,
    TAG_APE  = 2'd2
  } tag_kind_e;

  // "ID3"
  function automatic logic [BYTE_W-1:0] id3_ident(input logic [1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      2'd0:    ch = 8'h49;
      2'd1:    ch = 8'h44;
      default: ch = 8'h33;
    endcase
    return ch;
  endfunction

  // "APETAGEX"
  function automatic logic [BYTE_W-1:0] ape_ident(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h41;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h45;
      3'd3:    ch = 8'h54;
      3'd4:    ch = 8'h41;
      3'd5:    ch = 8'h47;
      3'd6:    ch = 8'h45;
      default: ch = 8'h58;
    endcase
    return ch;
  endfunction

endpackage

@@ hw/rtl/leading_tag_header_parser_unit.sv @@
// Channel   | Dir | Payload                                     | Handshake
// s_axis    | in  | tdata[7:0] byte_in, tlast window_end        | tvalid/tready
// m_axis    | out | tdata[32:0] tag_length, tuser kind and fail | tvalid/tready
// cfg       | in  | cfg_wdata_i file_size                       | cfg_we_i
//
// One byte a cycle while the input is not stalled: a byte lands in the input
// register and is scanned from there, and the window's last byte loads the
// result register.
// Reset clears the scan state; no clearing pass is needed.
// Bytes keep flowing while a result waits; only a second window end stalls
// the input until the waiting result is taken.
module leading_tag_header_parser_unit
  import lthp_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [WORD_W-1:0]      cfg_wdata_i,      // file_size
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,     // [7:0] byte_in
  input  logic                   s_axis_tlast,     // window_end
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,     // [32:0] tag_length, rest zero
  output logic [OUT_TUSER_W-1:0] m_axis_tuser      // [1:0] tag_kind, [2] fail
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_BYTES - 1);

  // Configuration register
  logic [WORD_W-1:0] fs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '0;
    end else if (cfg_we_i) begin
      fs_q <= cfg_wdata_i;
    end
  end

  // Input register
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              proc_fire;

  assign s_axis_tready = !in_vld_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Scan state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              id3_q, id3_d;
  logic              ape_q, ape_d;
  logic              foot_q, foot_d;
  logic [WORD_W-1:0] size_q, size_d;
  logic [WORD_W-1:0] ver_q, ver_d;
  logic              aflag_q, aflag_d;
  logic [LEN_W-1:0]  run_q, run_d;

  logic [POS_W-1:0]  p;
  logic [BYTE_W-1:0] b;
  logic              end_eff;
  tag_kind_e         kind;
  logic [LEN_W-1:0]  len;
  logic              fail;

  // Scan one byte against both header layouts
  always_comb begin
    p       = pos_q;
    b       = in_byte_q;
    id3_d   = id3_q;
    ape_d   = ape_q;
    foot_d  = foot_q;
    size_d  = size_q;
    ver_d   = ver_q;
    aflag_d = aflag_q;
    run_d   = run_q;

    if (id3_q) begin
      if (p < ID3_IDENT_END) begin
        if (b != id3_ident(p[1:0])) id3_d = 1'b0;
      end else if (p == ID3_VER_HI || p == ID3_VER_LO) begin
        if (b == BYTE_ALL_ONES) id3_d = 1'b0;
      end else if (p == ID3_FLAGS_POS) begin
        foot_d = b[4];
      end else if (p <= ID3_SIZE_LAST) begin
        if (b[7]) begin
          id3_d = 1'b0;
        end else begin
          size_d = {size_q[WORD_W-8:0], b[6:0]};
          if (p == ID3_SIZE_LAST) begin
            run_d = LEN_W'(size_d) + (foot_q ? ID3_HDR_FOOT_LEN : ID3_HDR_LEN);
          end
        end
      end else if (LEN_W'(p) == run_q && b == '0) begin
        // extend over zero padding
        run_d = run_q + LEN_W'(1);
      end
    end

    if (ape_q) begin
      if (p < APE_IDENT_END) begin
        if (b != ape_ident(p[2:0])) ape_d = 1'b0;
      end else if (p < APE_VER_END) begin
        ver_d = ver_q | (WORD_W'(b) << {p[1:0], 3'b000});
        if (p == APE_VER_LAST && ver_d != APE_VER_2000 && ver_d != APE_VER_1000) begin
          ape_d = 1'b0;
        end
      end else if (p < APE_SIZE_END) begin
        size_d = size_d | (WORD_W'(b) << {p[1:0], 3'b000});
      end else if (p == APE_FLAGS_TOP) begin
        aflag_d = b[7];
      end else if (p >= APE_RSVD_START && p < APE_RSVD_END) begin
        if (b != '0) ape_d = 1'b0;
      end
    end

    end_eff = in_last_q || (p >= LAST_POS);
    pos_d   = p + POS_W'(1);
  end

  // Pick the result of the window
  always_comb begin
    kind = TAG_NONE;
    len  = '0;
    if (id3_d && p >= ID3_SIZE_LAST) begin
      kind = TAG_ID3;
      len  = run_d;
    end else if (ape_d && p >= APE_HDR_LAST) begin
      kind = TAG_APE;
      len  = LEN_W'(size_d) +
             ((ver_d == APE_VER_2000 && aflag_d) ? APE_HDR_LEN : LEN_W'(0));
    end
    fail = (len >= LEN_W'(fs_q));
  end

  // Result register
  logic                  out_vld_q;
  logic [LEN_W-1:0]      out_len_q;
  tag_kind_e             out_kind_q;
  logic                  out_fail_q;
  logic                  out_free;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign proc_fire = in_vld_q && (!end_eff || out_free);

  // Advance or clear the scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      id3_q   <= 1'b1;
      ape_q   <= 1'b1;
      foot_q  <= 1'b0;
      size_q  <= '0;
      ver_q   <= '0;
      aflag_q <= 1'b0;
      run_q   <= '0;
    end else if (proc_fire) begin
      if (end_eff) begin
        pos_q   <= '0;
        id3_q   <= 1'b1;
        ape_q   <= 1'b1;
        foot_q  <= 1'b0;
        size_q  <= '0;
        ver_q   <= '0;
        aflag_q <= 1'b0;
        run_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        id3_q   <= id3_d;
        ape_q   <= ape_d;
        foot_q  <= foot_d;
        size_q  <= size_d;
        ver_q   <= ver_d;
        aflag_q <= aflag_d;
        run_q   <= run_d;
      end
    end
  end

  // Hold the result until the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_fire && end_eff) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && end_eff) begin
      out_len_q  <= len;
      out_kind_q <= kind;
      out_fail_q <= fail;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_len_q);
  assign m_axis_tuser  = {out_fail_q, out_kind_q};

endmodule

@@ hw/rtl/lthp_checker.sv @@
module lthp_checker
  import lthp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [WORD_W-1:0]      cfg_wdata_i,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [BYTE_W-1:0]      s_axis_tdata,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // Shadow of the file size register
  logic [WORD_W-1:0] fs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '0;
    end else if (cfg_we_i) begin
      fs_q <= cfg_wdata_i;
    end
  end

  logic in_xfer_unused;
  assign in_xfer_unused = s_axis_tvalid & s_axis_tready & s_axis_tlast & (&s_axis_tdata);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_none_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == TAG_NONE |-> m_axis_tdata == '0)
    else $error("no tag but nonzero length");

  a_id3_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == TAG_ID3 |-> m_axis_tdata[LEN_W-1:0] >= ID3_HDR_LEN)
    else $error("ID3v2 length below header size");

  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !in_xfer_unused |->
      m_axis_tuser[2] == (m_axis_tdata[LEN_W-1:0] >= LEN_W'(fs_q)))
    else $error("fail flag disagrees with file size");

endmodule

bind leading_tag_header_parser_unit lthp_checker u_lthp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
